FILE: design/assert_macros.svh
// Assertion macros shared by the gamepad frame decoder RTL.
// Stand-alone header; the including module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property, disabled while reset is asserted.
`define GFDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked property that is also checked during reset.
`define GFDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define GFDC_ASSERT(lbl, prop, msg)
`define GFDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/gfdc_pkg.sv
// Shared types, constants and helper functions for the gamepad frame decoder.
// No dependencies; used by gfdc_div, the top-level unit and its testbench.
package gfdc_pkg;

  // Stick axes in the order right X, right Y, left X, left Y.
  localparam int NUM_AXES           = 4;
  localparam int AXIS_W             = 2;
  localparam int DEFAULT_AXIS_COUNT = 4;

  localparam logic [7:0] ANALOG_ID  = 8'hCE;
  localparam logic [7:0] BYTE_MAX   = 8'd255;

  // Divider sizing: span is at most 127, quotient at most 127.
  localparam int SPAN_W = 7;
  localparam int QUO_W  = 7;
  localparam int NUM_W  = SPAN_W + QUO_W;

  typedef struct packed {
    logic [7:0] id_byte;
    logic [7:0] button_byte_low;
    logic [7:0] button_byte_high;
    logic [7:0] right_x_byte;
    logic [7:0] right_y_byte;
    logic [7:0] left_x_byte;
    logic [7:0] left_y_byte;
  } frame_req_t;

  typedef struct packed {
    logic [15:0]       buttons_pressed;
    logic              analog_active;
    logic [7:0]        right_x_value;
    logic [7:0]        right_y_value;
    logic [7:0]        left_x_value;
    logic [7:0]        left_y_value;
    logic signed [7:0] right_x_scaled;
    logic signed [7:0] right_y_scaled;
    logic signed [7:0] left_x_scaled;
    logic signed [7:0] left_y_scaled;
  } frame_rsp_t;

  // Request into the shared divider.
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [SPAN_W-1:0] den;
  } div_req_t;

  // Status back from the shared divider.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } seq_state_e;

  // Reverse the bit order of one byte by nibble, pair and bit swaps.
  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] v;
    v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
    v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
    return v;
  endfunction

endpackage

FILE: design/gfdc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on gfdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gfdc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gfdc_pkg::div_req_t div_req_i,
  output gfdc_pkg::div_rsp_t div_rsp_o
);

  localparam int SPAN_W = gfdc_pkg::SPAN_W;
  localparam int QUO_W  = gfdc_pkg::QUO_W;
  localparam int NUM_W  = gfdc_pkg::NUM_W;
  localparam int CNT_W  = $clog2(QUO_W);

  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [SPAN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SPAN_W+1:0] trial;

  // The caller guarantees num <= 127 * den, so the upper bits start below den
  // and only QUO_W steps are needed.
  always_comb begin
    trial  = {1'b0, rem_q, quo_q[QUO_W-1]} - {2'b00, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (div_req_i.start) begin
      rem_d  = div_req_i.num[NUM_W-1:QUO_W];
      quo_d  = div_req_i.num[QUO_W-1:0];
      den_d  = div_req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[SPAN_W+1]) begin
        rem_d = trial[SPAN_W-1:0];
      end else begin
        rem_d = {rem_q[SPAN_W-2:0], quo_q[QUO_W-1]};
      end
      quo_d = {quo_q[QUO_W-2:0], ~trial[SPAN_W+1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign div_rsp_o.done = done_q;
  assign div_rsp_o.quot = quo_q;

  `GFDC_ASSERT(a_div_no_restart, div_req_i.start |-> !busy_q, "divider restarted while busy")
  `GFDC_ASSERT(a_div_start_busy, div_req_i.start |=> busy_q, "divider did not start")
  `GFDC_ASSERT(a_div_done_after_busy, done_q |-> $past(busy_q), "done without a division")

endmodule

FILE: design/gamepad_frame_decode_calibrate_unit.sv
// Top level of the gamepad frame decoder with stick-center calibration.
// Depends on gfdc_pkg, gfdc_div and assert_macros.svh.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------
//   frame   | in        | in_valid_i/in_stall_o   | in_req_i  (frame_req_t)
//   result  | out       | out_valid_o/out_stall_i | out_rsp_o (frame_rsp_t)
//
// A frame is accepted in the idle state. Each calibrated axis then enters the prepare
// state; with a nonzero span it goes on to the load state, which starts the shared
// divider, and waits in the divide state as the divider forms one quotient bit per
// cycle. An axis with a zero span gets a scaled value of zero in the prepare state.
// After the last axis the finish state loads the result register and returns to idle.
// Reset clears the sequencer, the previous-mode flag and the stick centers.
// A stalled result holds in the output register; the next frame is taken
// meanwhile and waits in the finish state until the register is free.
`include "assert_macros.svh"

module gamepad_frame_decode_calibrate_unit #(
  parameter int AXIS_COUNT = gfdc_pkg::DEFAULT_AXIS_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gfdc_pkg::frame_req_t in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gfdc_pkg::frame_rsp_t out_rsp_o
);

  localparam int NUM_AXES = gfdc_pkg::NUM_AXES;
  localparam int AXIS_W   = gfdc_pkg::AXIS_W;
  localparam int SPAN_W   = gfdc_pkg::SPAN_W;
  localparam int QUO_W    = gfdc_pkg::QUO_W;
  localparam int NUM_W    = gfdc_pkg::NUM_W;

  gfdc_pkg::seq_state_e state_q, state_d;

  logic [AXIS_W-1:0]  axis_q, axis_d;
  logic               was_analog_q, was_analog_d;
  logic [7:0]         center_q [NUM_AXES];
  logic [7:0]         center_d [NUM_AXES];
  logic [7:0]         pos_q    [NUM_AXES];
  logic [7:0]         pos_d    [NUM_AXES];
  logic [7:0]         scaled_q [NUM_AXES];
  logic [7:0]         scaled_d [NUM_AXES];
  logic [15:0]        buttons_q, buttons_d;
  logic               analog_q, analog_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [SPAN_W-1:0]  den_q, den_d;
  logic               neg_q, neg_d;
  logic               out_valid_q, out_valid_d;
  gfdc_pkg::frame_rsp_t out_rsp_q, out_rsp_d;

  logic               in_fire;
  logic               in_analog;
  logic               last_axis;
  logic               out_free;
  logic [7:0]         ctr;
  logic [7:0]         pos;
  logic [SPAN_W-1:0]  span;
  logic               neg;
  logic [7:0]         absv;
  logic [SPAN_W-1:0]  mag;
  logic [NUM_W-1:0]   num;
  logic [7:0]         quot_ext;

  gfdc_pkg::div_req_t div_req;
  gfdc_pkg::div_rsp_t div_rsp;

  assign in_stall_o = (state_q != gfdc_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_analog  = (in_req_i.id_byte == gfdc_pkg::ANALOG_ID);
  assign last_axis  = (axis_q == AXIS_W'(AXIS_COUNT - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Axis operands: span to the nearer end, clamped magnitude times 127.
  always_comb begin
    ctr  = center_q[axis_q];
    pos  = pos_q[axis_q];
    span = ctr[7] ? SPAN_W'(gfdc_pkg::BYTE_MAX - ctr) : ctr[SPAN_W-1:0];
    neg  = (pos < ctr);
    absv = neg ? (ctr - pos) : (pos - ctr);
    mag  = (absv > {1'b0, span}) ? span : absv[SPAN_W-1:0];
    num  = {mag, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, mag};
  end

  assign quot_ext = {1'b0, div_rsp.quot};

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfdc_pkg::ST_IDLE: begin
        if (in_fire) state_d = gfdc_pkg::ST_PREP;
      end
      gfdc_pkg::ST_PREP: begin
        if (span != '0)     state_d = gfdc_pkg::ST_LOAD;
        else if (last_axis) state_d = gfdc_pkg::ST_FINISH;
      end
      gfdc_pkg::ST_LOAD: begin
        state_d = gfdc_pkg::ST_DIV;
      end
      gfdc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = last_axis ? gfdc_pkg::ST_FINISH : gfdc_pkg::ST_PREP;
        end
      end
      gfdc_pkg::ST_FINISH: begin
        if (out_free) state_d = gfdc_pkg::ST_IDLE;
      end
      default: state_d = gfdc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and register updates driven by the sequencer.
  always_comb begin
    axis_d       = axis_q;
    was_analog_d = was_analog_q;
    center_d     = center_q;
    pos_d        = pos_q;
    scaled_d     = scaled_q;
    buttons_d    = buttons_q;
    analog_d     = analog_q;
    num_d        = num_q;
    den_d        = den_q;
    neg_d        = neg_q;
    out_rsp_d    = out_rsp_q;
    out_valid_d  = out_valid_q && out_stall_i;
    div_req      = '0;
    div_req.num  = num_q;
    div_req.den  = den_q;

    unique case (state_q)
      gfdc_pkg::ST_IDLE: begin
        if (in_fire) begin
          buttons_d    = ~{in_req_i.button_byte_high, in_req_i.button_byte_low};
          analog_d     = in_analog;
          was_analog_d = in_analog;
          axis_d       = '0;
          pos_d[0]     = gfdc_pkg::flip8(in_req_i.right_x_byte);
          pos_d[1]     = gfdc_pkg::flip8(in_req_i.right_y_byte);
          pos_d[2]     = gfdc_pkg::flip8(in_req_i.left_x_byte);
          pos_d[3]     = gfdc_pkg::flip8(in_req_i.left_y_byte);
          for (int k = 0; k < NUM_AXES; k++) begin
            scaled_d[k] = '0;
            // Rising edge of analog mode captures this frame's positions.
            if (in_analog && !was_analog_q && (k < AXIS_COUNT)) begin
              center_d[k] = pos_d[k];
            end
          end
        end
      end
      gfdc_pkg::ST_PREP: begin
        num_d = num;
        den_d = span;
        neg_d = neg;
        if (span == '0) begin
          scaled_d[axis_q] = '0;
          if (!last_axis) axis_d = axis_q + AXIS_W'(1);
        end
      end
      gfdc_pkg::ST_LOAD: begin
        div_req.start = 1'b1;
      end
      gfdc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          scaled_d[axis_q] = neg_q ? (8'd0 - quot_ext) : quot_ext;
          if (!last_axis) axis_d = axis_q + AXIS_W'(1);
        end
      end
      gfdc_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_rsp_d.buttons_pressed = buttons_q;
          out_rsp_d.analog_active   = analog_q;
          out_rsp_d.right_x_value   = pos_q[0];
          out_rsp_d.right_y_value   = pos_q[1];
          out_rsp_d.left_x_value    = pos_q[2];
          out_rsp_d.left_y_value    = pos_q[3];
          out_rsp_d.right_x_scaled  = scaled_q[0];
          out_rsp_d.right_y_scaled  = scaled_q[1];
          out_rsp_d.left_x_scaled   = scaled_q[2];
          out_rsp_d.left_y_scaled   = scaled_q[3];
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // Control state and the calibration centers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gfdc_pkg::ST_IDLE;
      axis_q       <= '0;
      was_analog_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
        center_q[k] <= '0;
      end
    end else begin
      state_q      <= state_d;
      axis_q       <= axis_d;
      was_analog_q <= was_analog_d;
      out_valid_q  <= out_valid_d;
      center_q     <= center_d;
    end
  end

  // Working copy of the frame and the output register.
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    scaled_q  <= scaled_d;
    buttons_q <= buttons_d;
    analog_q  <= analog_d;
    num_q     <= num_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    out_rsp_q <= out_rsp_d;
  end

  gfdc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `GFDC_ASSERT(a_out_from_finish,
               $rose(out_valid_o) |-> $past(state_q == gfdc_pkg::ST_FINISH),
               "result raised outside finish")
  `GFDC_ASSERT(a_done_in_div,
               div_rsp.done |-> (state_q == gfdc_pkg::ST_DIV),
               "divider done outside divide state")
  `GFDC_ASSERT(a_scaled_range,
               out_valid_o |-> ((out_rsp_o.right_x_scaled != 8'sh80) &&
                                (out_rsp_o.right_y_scaled != 8'sh80) &&
                                (out_rsp_o.left_x_scaled != 8'sh80) &&
                                (out_rsp_o.left_y_scaled != 8'sh80)),
               "scaled value out of range")

endmodule

FILE: sim/tb_gamepad_frame_decode_calibrate_unit.sv
// Self-checking testbench for gamepad_frame_decode_calibrate_unit: directed and random requests,
// results checked field by field against given results or a local decoder and calibration model.
// Depends on gfdc_pkg and the unit under test only.
module tb_gamepad_frame_decode_calibrate_unit;
  import gfdc_pkg::*;

  localparam int AXIS_COUNT     = DEFAULT_AXIS_COUNT;
  localparam int RANDOM_FRAMES  = 1630;
  localparam int CALM_FRAMES    = 150;
  localparam int DRAIN_CYCLES   = 60;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 19;

  // One directed request; has_rsp marks rows whose result is written out here.
  typedef struct packed {
    logic       has_rsp;
    frame_req_t req;
    frame_rsp_t rsp;
  } directed_row_t;

  // Request fields: id, button low, button high, right x, right y, left x, left y.
  // Result fields: buttons, analog, four values, four scaled values.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Reset centers are zero, so every scaled field is zero.
    {1'b1, 56'h00_00_00_00_00_00_00, 16'hFFFF, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    {1'b1, 56'hFF_FF_FF_FF_FF_FF_FF, 16'h0000, 1'b0, 32'hFF_FF_FF_FF, 32'h00_00_00_00},
    // Entering analog mode with every stick at full scale: zero span.
    {1'b1, 56'hCE_00_FF_FF_FF_FF_FF, 16'h00FF, 1'b1, 32'hFF_FF_FF_FF, 32'h00_00_00_00},
    {1'b1, 56'hCE_A5_5A_00_00_00_00, 16'hA55A, 1'b1, 32'h00_00_00_00, 32'h00_00_00_00},
    {1'b1, 56'hCF_0F_F0_01_01_01_01, 16'h0FF0, 1'b0, 32'h80_80_80_80, 32'h00_00_00_00},
    // Capture at mid scale, then both ends, the low end clamped.
    {1'b1, 56'hCE_55_AA_01_01_01_01, 16'h55AA, 1'b1, 32'h80_80_80_80, 32'h00_00_00_00},
    {1'b1, 56'hCE_FF_FF_FF_FF_FF_FF, 16'h0000, 1'b1, 32'hFF_FF_FF_FF, 32'h7F_7F_7F_7F},
    {1'b1, 56'hCE_00_00_00_00_00_00, 16'hFFFF, 1'b1, 32'h00_00_00_00, 32'h81_81_81_81},
    {1'b0, 56'hCE_12_34_02_80_FE_7F, 16'h0000, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    // The bit-reversed analog id does not count as analog mode.
    {1'b0, 56'h73_FE_EF_10_20_30_40, 16'h0000, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    {1'b1, 56'hCE_00_00_FE_FE_FE_FE, 16'hFFFF, 1'b1, 32'h7F_7F_7F_7F, 32'h00_00_00_00},
    {1'b1, 56'hCE_FF_00_FF_00_FF_00, 16'hFF00, 1'b1, 32'hFF_00_FF_00, 32'h7F_81_7F_81},
    {1'b0, 56'h00_C3_3C_9C_3A_C5_66, 16'h0000, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    // Capture with spans of one on the right stick and uneven spans on the left.
    {1'b0, 56'hCE_81_18_80_7F_26_6D, 16'h0000, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    {1'b0, 56'hCE_7E_E7_00_FF_84_4B, 16'h0000, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    {1'b0, 56'hCE_99_66_C3_3C_99_81, 16'h0000, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    // Out of analog mode the old centers still apply.
    {1'b0, 56'h00_F0_0F_11_22_44_88, 16'h0000, 1'b0, 32'h00_00_00_00, 32'h00_00_00_00},
    // Capture at zero, then full scale against that center.
    {1'b1, 56'hCE_5A_A5_00_00_00_00, 16'h5AA5, 1'b1, 32'h00_00_00_00, 32'h00_00_00_00},
    {1'b1, 56'hCE_FF_FF_FF_FF_FF_FF, 16'h0000, 1'b1, 32'hFF_FF_FF_FF, 32'h00_00_00_00}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  frame_req_t in_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  frame_rsp_t out_rsp_o;

  // Model state: previous analog mode and the captured stick centers.
  logic       prev_analog;
  logic [7:0] stick_center [NUM_AXES];

  frame_rsp_t pending_rsp_q [$];
  logic       quiet;
  int         stall_left;
  int         cycles;
  int         mismatches;
  int         frames_sent;
  int         results_seen;
  int         center_captures;
  int         zero_span_axes;

  gamepad_frame_decode_calibrate_unit #(
    .AXIS_COUNT(AXIS_COUNT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] reverse_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7 - i];
    end
    return r;
  endfunction

  // Decode one request and update the calibration state, as the unit does.
  function automatic frame_rsp_t decode_frame(input frame_req_t f);
    logic [7:0]        pos    [NUM_AXES];
    logic signed [7:0] scaled [NUM_AXES];
    logic              analog;
    int                span;
    int                off;
    frame_rsp_t        r;
    pos[0] = reverse_byte(f.right_x_byte);
    pos[1] = reverse_byte(f.right_y_byte);
    pos[2] = reverse_byte(f.left_x_byte);
    pos[3] = reverse_byte(f.left_y_byte);
    analog = (f.id_byte == ANALOG_ID);
    // Centers are taken from the request that enters analog mode.
    if (analog && !prev_analog) begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
        stick_center[k] = pos[k];
      end
      center_captures++;
    end
    prev_analog = analog;
    for (int k = 0; k < NUM_AXES; k++) begin
      scaled[k] = '0;
      if (k < AXIS_COUNT) begin
        span = (stick_center[k] > 8'd127) ? 255 - int'(stick_center[k])
                                          : int'(stick_center[k]);
        if (span == 0) begin
          zero_span_axes++;
        end else begin
          off = int'(pos[k]) - int'(stick_center[k]);
          if (off > span) off = span;
          if (off < -span) off = -span;
          scaled[k] = 8'((off * 127) / span);
        end
      end
    end
    r.buttons_pressed = ~{f.button_byte_high, f.button_byte_low};
    r.analog_active   = analog;
    r.right_x_value   = pos[0];
    r.right_y_value   = pos[1];
    r.left_x_value    = pos[2];
    r.left_y_value    = pos[3];
    r.right_x_scaled  = scaled[0];
    r.right_y_scaled  = scaled[1];
    r.left_x_scaled   = scaled[2];
    r.left_y_scaled   = scaled[3];
    return r;
  endfunction

  // Random request; stick positions lean toward the ends and the middle.
  function automatic frame_req_t make_frame(input logic analog);
    logic [7:0] pos [NUM_AXES];
    frame_req_t f;
    for (int k = 0; k < NUM_AXES; k++) begin
      case ($urandom_range(0, 7))
        0:       pos[k] = ($urandom_range(0, 1) != 0) ? 8'(254 + $urandom_range(0, 1))
                                                      : 8'($urandom_range(0, 1));
        1:       pos[k] = 8'($urandom_range(120, 135));
        default: pos[k] = 8'($urandom_range(0, 255));
      endcase
    end
    f.id_byte = 8'($urandom_range(0, 255));
    if (analog) begin
      f.id_byte = ANALOG_ID;
    end else if (f.id_byte == ANALOG_ID) begin
      f.id_byte = f.id_byte ^ 8'h01;
    end
    f.button_byte_low  = 8'($urandom);
    f.button_byte_high = 8'($urandom);
    f.right_x_byte     = reverse_byte(pos[0]);
    f.right_y_byte     = reverse_byte(pos[1]);
    f.left_x_byte      = reverse_byte(pos[2]);
    f.left_y_byte      = reverse_byte(pos[3]);
    return f;
  endfunction

  // Present one request, hold it until accepted, then queue its result.
  task automatic send_frame(input frame_req_t f, input logic has_rsp, input frame_rsp_t rsp);
    frame_rsp_t want;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= f;
    do @(posedge clk_i); while (in_stall_o);
    want = decode_frame(f);
    pending_rsp_q.push_back(has_rsp ? rsp : want);
    frames_sent++;
  endtask

  task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch on result %0d, %s: expected %0h, got %0h",
               results_seen, what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) report(what, want, got);
  endtask

  task automatic check_result(input frame_rsp_t got);
    frame_rsp_t want;
    if (pending_rsp_q.size() == 0) begin
      report("result with no request outstanding", 16'h0, got.buttons_pressed);
    end else begin
      want = pending_rsp_q.pop_front();
      check_field("buttons_pressed", want.buttons_pressed, got.buttons_pressed);
      check_field("analog_active", 16'(want.analog_active), 16'(got.analog_active));
      check_field("right_x_value", 16'(want.right_x_value), 16'(got.right_x_value));
      check_field("right_y_value", 16'(want.right_y_value), 16'(got.right_y_value));
      check_field("left_x_value", 16'(want.left_x_value), 16'(got.left_x_value));
      check_field("left_y_value", 16'(want.left_y_value), 16'(got.left_y_value));
      check_field("right_x_scaled", 16'(want.right_x_scaled), 16'(got.right_x_scaled));
      check_field("right_y_scaled", 16'(want.right_y_scaled), 16'(got.right_y_scaled));
      check_field("left_x_scaled", 16'(want.left_x_scaled), 16'(got.left_x_scaled));
      check_field("left_y_scaled", 16'(want.left_y_scaled), 16'(got.left_y_scaled));
    end
    results_seen++;
  endtask

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_rsp_o);
  end

  // Result stalls come in short bursts, none during the quiet tail.
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_rsp_q.size());
      $display("gamepad_frame_decode_calibrate_unit regression: fail");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    frame_req_t f;
    int         run;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    out_stall_i     = 1'b0;
    quiet           = 1'b0;
    stall_left      = 0;
    cycles          = 0;
    mismatches      = 0;
    frames_sent     = 0;
    results_seen    = 0;
    center_captures = 0;
    zero_span_axes  = 0;
    prev_analog     = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      stick_center[k] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_frame(DIRECTED[i].req, DIRECTED[i].has_rsp, DIRECTED[i].rsp);
    end

    // Random part: mostly analog sessions (entry, capture, motion, exit), some noise.
    while (frames_sent < DIRECTED_ROWS + RANDOM_FRAMES) begin
      quiet = (frames_sent >= DIRECTED_ROWS + RANDOM_FRAMES - CALM_FRAMES);
      if ($urandom_range(0, 7) == 0) begin
        f = make_frame($urandom_range(0, 3) == 0);
        send_frame(f, 1'b0, '0);
      end else begin
        send_frame(make_frame(1'b0), 1'b0, '0);
        run = $urandom_range(3, 13);
        repeat (run) send_frame(make_frame(1'b1), 1'b0, '0);
        run = $urandom_range(0, 3);
        repeat (run) send_frame(make_frame(1'b0), 1'b0, '0);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked, %0d mismatches",
             frames_sent, results_seen, mismatches);
    $display("%0d center captures, %0d scaled axes with zero span",
             center_captures, zero_span_axes);
    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("gamepad_frame_decode_calibrate_unit regression: pass");
    end else begin
      $display("gamepad_frame_decode_calibrate_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: gamepad_frame_decode_calibrate_unit.f
+incdir+design
design/gfdc_pkg.sv
design/gfdc_div.sv
design/gamepad_frame_decode_calibrate_unit.sv
sim/tb_gamepad_frame_decode_calibrate_unit.sv
